// File: rtl/flg_pkg.sv
package flg_pkg;

    localparam int DELAY_LENGTH_DEF    = 480;
    localparam int RATE_HZ_DEF         = 48000;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int Q15_ONE = 32768;
    localparam int SIN_A   = 51472;
    localparam int SIN_B   = 21024;
    localparam int SIN_C   = 2320;

    // register word index, taken from paddr[3:2]
    localparam logic [1:0] REG_PHASE_STEP    = 2'd0;
    localparam logic [1:0] REG_MOD_DEPTH     = 2'd1;
    localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd2;
    localparam logic [1:0] REG_WET_MIX       = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FB,
        ST_WR,
        ST_X2C,
        ST_T1,
        ST_T2,
        ST_SIN,
        ST_SK,
        ST_DLY,
        ST_MOD,
        ST_RD1,
        ST_RD2,
        ST_INT,
        ST_DEL,
        ST_MIX
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_FB,
        OP_WR,
        OP_X2C,
        OP_T1,
        OP_T2,
        OP_SIN,
        OP_SK,
        OP_DLY,
        OP_MOD,
        OP_RD1,
        OP_RD2,
        OP_INT,
        OP_DEL,
        OP_MIX
    } t_op;

    typedef struct packed {
        t_op  op;
        logic mem_we;
        logic prod_en;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic [30:0]        phase_step;
        logic [15:0]        mod_depth;
        logic signed [15:0] feedback_gain;
        logic [15:0]        wet_mix;
    } t_cfg;

endpackage

// File: rtl/flg_ram.sv
module flg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 480
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/flg_ctrl.sv
module flg_ctrl
    import flg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_FB;
            ST_FB:    n_state = ST_WR;
            ST_WR:    n_state = ST_X2C;
            ST_X2C:   n_state = ST_T1;
            ST_T1:    n_state = ST_T2;
            ST_T2:    n_state = ST_SIN;
            ST_SIN:   n_state = ST_SK;
            ST_SK:    n_state = ST_DLY;
            ST_DLY:   n_state = ST_MOD;
            ST_MOD:   if (i_stat.mod_last) n_state = ST_RD1;
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_INT;
            ST_INT:   n_state = ST_DEL;
            ST_DEL:   n_state = ST_MIX;
            ST_MIX:   if (!i_stat.out_busy) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            ST_CLEAR: o_cmd.op = OP_CLEAR;
            ST_IDLE:  if (i_in_valid) o_cmd.op = OP_LOAD;
            ST_FB:    o_cmd.op = OP_FB;
            ST_WR:    o_cmd.op = OP_WR;
            ST_X2C:   o_cmd.op = OP_X2C;
            ST_T1:    o_cmd.op = OP_T1;
            ST_T2:    o_cmd.op = OP_T2;
            ST_SIN:   o_cmd.op = OP_SIN;
            ST_SK:    o_cmd.op = OP_SK;
            ST_DLY:   o_cmd.op = OP_DLY;
            ST_MOD:   o_cmd.op = OP_MOD;
            ST_RD1:   o_cmd.op = OP_RD1;
            ST_RD2:   o_cmd.op = OP_RD2;
            ST_INT:   o_cmd.op = OP_INT;
            ST_DEL:   o_cmd.op = OP_DEL;
            // hold the result until the output register frees up
            ST_MIX:   if (!i_stat.out_busy) o_cmd.op = OP_MIX;
            default:  o_cmd.op = OP_NONE;
        endcase
        o_cmd.mem_we  = (o_cmd.op == OP_CLEAR) || (o_cmd.op == OP_WR);
        o_cmd.prod_en = (o_cmd.op == OP_FB)  || (o_cmd.op == OP_WR)  ||
                        (o_cmd.op == OP_X2C) || (o_cmd.op == OP_T1)  ||
                        (o_cmd.op == OP_T2)  || (o_cmd.op == OP_SIN) ||
                        (o_cmd.op == OP_SK)  || (o_cmd.op == OP_INT) ||
                        (o_cmd.op == OP_DEL);
    end

endmodule

// File: rtl/flg_dp.sv
module flg_dp
    import flg_pkg::*;
#(
    parameter int DELAY_LENGTH    = DELAY_LENGTH_DEF,
    parameter int RATE_HZ         = RATE_HZ_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  t_cfg               i_cfg,
    input  logic signed [15:0] i_sample,
    output logic signed [15:0] o_sample,
    output logic               o_valid,
    input  logic               i_ready
);

    localparam int AW    = $clog2(DELAY_LENGTH);
    localparam int SPAN  = DELAY_LENGTH * 256;
    localparam int KMUL  = RATE_HZ * 2048 / 1000;
    localparam int BASE  = RATE_HZ * 512 / 1000;
    localparam int OFF   = (BASE + KMUL) / SPAN + 1;
    localparam int VMAX  = (OFF + 1) * SPAN + KMUL;
    localparam int VOFS  = OFF * SPAN - BASE;
    localparam int VW    = $clog2(VMAX + 1);
    localparam int QB    = $clog2(VMAX / SPAN + 1);
    localparam int SW    = (QB > 1) ? $clog2(QB) : 1;
    localparam int DW    = $clog2(KMUL + 1) + 1;
    localparam int EW    = VW + DW;
    localparam int QBITS = SINE_TABLE_BITS - 2;
    localparam int MA    = 32;
    localparam int MB    = 21;
    localparam int PW    = MA + MB;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'sh7fff;
        end else if (v < -19'sd32768) begin
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

    logic signed [15:0]   r_x;
    logic [15:0]          r_sx;
    logic                 r_neg;
    logic [15:0]          r_x2;
    logic signed [PW-1:0] r_prod;
    logic [VW-1:0]        r_v;
    logic [SW-1:0]        r_step;
    logic [AW-1:0]        r_clr;
    logic [AW-1:0]        r_wp;
    logic [31:0]          r_phase;
    logic signed [15:0]   r_st1;
    logic signed [15:0]   r_out;
    logic                 r_out_valid;

    logic signed [15:0]   n_x;
    logic [15:0]          n_sx;
    logic                 n_neg;
    logic [15:0]          n_x2;
    logic [VW-1:0]        n_v;
    logic [SW-1:0]        n_step;
    logic [AW-1:0]        n_clr;
    logic [AW-1:0]        n_wp;
    logic [31:0]          n_phase;
    logic signed [15:0]   n_st1;
    logic signed [15:0]   n_out;
    logic                 n_out_valid;

    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [15:0]          w_xq;
    logic [15:0]          w_sx;
    logic [15:0]          w_depth;
    logic [15:0]          w_wet;
    logic [15:0]          w_rdata;
    logic signed [15:0]   w_rd;
    logic [15:0]          w_hi;
    logic [15:0]          w_t1;
    logic [15:0]          w_t2;
    logic [16:0]          w_sq;
    logic [14:0]          w_smag;
    logic signed [16:0]   w_s;
    logic signed [16:0]   w_fb;
    logic signed [17:0]   w_wsum;
    logic signed [15:0]   w_wval;
    logic [7:0]           w_f;
    logic [AW-1:0]        w_i1;
    logic [AW-1:0]        w_i2;
    logic signed [16:0]   w_diff;
    logic signed [25:0]   w_acc;
    logic signed [15:0]   w_del;
    logic signed [16:0]   w_diff2;
    logic signed [33:0]   w_mix;
    logic signed [15:0]   w_y;
    logic signed [DW-1:0] w_dterm;
    logic [EW-1:0]        w_dext;
    logic [VW-1:0]        w_vnew;
    logic [VW-1:0]        w_cmp;
    logic signed [MA-1:0] w_ma;
    logic signed [MB-1:0] w_mb;
    logic signed [PW-1:0] w_mul;
    logic [AW-1:0]        w_addr;
    logic [15:0]          w_wdata;

    // sine lookup position from the top bits of the phase accumulator
    assign w_idx = r_phase[31 -: SINE_TABLE_BITS];
    assign w_xq  = 16'(w_idx[QBITS-1:0]) << (15 - QBITS);
    assign w_sx  = w_idx[QBITS] ? 16'(Q15_ONE) - w_xq : w_xq;

    assign w_depth = (i_cfg.mod_depth > 16'(Q15_ONE)) ? 16'(Q15_ONE) : i_cfg.mod_depth;
    assign w_wet   = (i_cfg.wet_mix > 16'(Q15_ONE)) ? 16'(Q15_ONE) : i_cfg.wet_mix;

    assign w_rd = $signed(w_rdata);

    // polynomial terms, previous product taken down by 15 bits
    assign w_hi   = r_prod[30:15];
    assign w_t1   = 16'(SIN_B) - w_hi;
    assign w_t2   = 16'(SIN_A) - w_hi;
    assign w_sq   = r_prod[31:15];
    assign w_smag = (w_sq > 17'd32767) ? 15'h7fff : w_sq[14:0];
    assign w_s    = r_neg ? -$signed({2'b00, w_smag}) : $signed({2'b00, w_smag});

    assign w_fb   = r_prod[31:15];
    assign w_wsum = {{2{r_x[15]}}, r_x} + {w_fb[16], w_fb};
    assign w_wval = sat16({w_wsum[17], w_wsum});

    assign w_f  = r_v[7:0];
    assign w_i1 = r_v[AW+7:8];
    assign w_i2 = (w_i1 == AW'(DELAY_LENGTH - 1)) ? '0 : w_i1 + AW'(1);

    // interpolation as st1*256 + (st2-st1)*f
    assign w_diff  = {w_rd[15], w_rd} - {r_st1[15], r_st1};
    assign w_acc   = {{2{r_st1[15]}}, r_st1, 8'd0} + r_prod[25:0];
    assign w_del   = w_acc[23:8];
    assign w_diff2 = {w_del[15], w_del} - {r_x[15], r_x};

    // mix as x*32768 + (delayed-x)*wet
    assign w_mix = {{3{r_x[15]}}, r_x, 15'd0} + r_prod[33:0];
    assign w_y   = sat16(w_mix[33:15]);

    // read position, biased positive by whole buffer lengths
    assign w_dterm = r_prod[30+DW-1:30];
    assign w_dext  = {{VW{w_dterm[DW-1]}}, w_dterm};
    assign w_vnew  = VW'(EW'({r_wp, 8'd0}) + EW'(VOFS) - w_dext);
    assign w_cmp   = VW'(SPAN) << r_step;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            OP_FB: begin
                w_ma = MA'(w_rd);
                w_mb = MB'(i_cfg.feedback_gain);
            end
            OP_WR: begin
                w_ma = MA'(r_sx);
                w_mb = MB'(r_sx);
            end
            OP_X2C: begin
                w_ma = MA'(w_hi);
                w_mb = MB'(SIN_C);
            end
            OP_T1: begin
                w_ma = MA'(r_x2);
                w_mb = MB'(w_t1);
            end
            OP_T2: begin
                w_ma = MA'(r_sx);
                w_mb = MB'(w_t2);
            end
            OP_SIN: begin
                w_ma = MA'(w_s);
                w_mb = MB'(w_depth);
            end
            OP_SK: begin
                w_ma = MA'($signed(r_prod[30:0]));
                w_mb = MB'(KMUL);
            end
            OP_INT: begin
                w_ma = MA'(w_diff);
                w_mb = MB'(w_f);
            end
            OP_DEL: begin
                w_ma = MA'(w_diff2);
                w_mb = MB'(w_wet);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul = w_ma * w_mb;

    always_comb begin
        unique case (i_cmd.op)
            OP_CLEAR: w_addr = r_clr;
            OP_RD1:   w_addr = w_i1;
            OP_RD2:   w_addr = w_i2;
            default:  w_addr = r_wp;
        endcase
        w_wdata = (i_cmd.op == OP_CLEAR) ? '0 : w_wval;
    end

    flg_ram #(
        .WIDTH (16),
        .DEPTH (DELAY_LENGTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_x         = r_x;
        n_sx        = r_sx;
        n_neg       = r_neg;
        n_x2        = r_x2;
        n_v         = r_v;
        n_step      = r_step;
        n_clr       = r_clr;
        n_wp        = r_wp;
        n_phase     = r_phase;
        n_st1       = r_st1;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        unique case (i_cmd.op)
            OP_CLEAR: n_clr = r_clr + AW'(1);
            OP_LOAD: begin
                n_x     = i_sample;
                n_sx    = w_sx;
                n_neg   = w_idx[QBITS+1];
                n_phase = r_phase + 32'(i_cfg.phase_step);
            end
            OP_X2C: n_x2 = w_hi;
            OP_DLY: begin
                n_v    = w_vnew;
                n_step = SW'(QB - 1);
            end
            OP_MOD: begin
                if (r_v >= w_cmp) begin
                    n_v = r_v - w_cmp;
                end
                n_step = r_step - SW'(1);
            end
            OP_RD2: n_st1 = w_rd;
            OP_MIX: begin
                n_out       = w_y;
                n_out_valid = 1'b1;
                n_wp        = (r_wp == AW'(DELAY_LENGTH - 1)) ? '0 : r_wp + AW'(1);
            end
            default: n_x = r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_wp        <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_clr       <= n_clr;
            r_wp        <= n_wp;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_sx  <= n_sx;
        r_neg <= n_neg;
        r_x2  <= n_x2;
        r_v   <= n_v;
        r_st1 <= n_st1;
        r_out <= n_out;
        if (i_cmd.prod_en) begin
            r_prod <= w_mul;
        end
    end

    assign o_stat.clr_last = (r_clr == AW'(DELAY_LENGTH - 1));
    assign o_stat.mod_last = (r_step == '0);
    assign o_stat.out_busy = r_out_valid && !i_ready;

    assign o_sample = r_out;
    assign o_valid  = r_out_valid;

endmodule

// File: rtl/flanger_effect.sv
// Flanger: one Q1.15 sample in, one Q1.15 sample out on stream ports. Each input is summed
// with the oldest stored sample scaled by feedback_gain and written into a circular delay
// memory; a sine LFO sweeps a fractional tap (2 ms plus sine times 8 ms times depth) whose
// two neighboring entries are interpolated and mixed with the dry sample by wet_mix. Items
// are processed one at a time by the single 32x21 multiplier that the controller walks
// through nine products and by the single-port delay memory. A finished result waits in
// the output register while the next item is accepted. After reset the block zeroes every
// entry of the delay memory (DELAY_LENGTH entries, 480 by default) and takes no item during
// that pass; APB writes are taken at any time and must only be issued idle.
module flanger_effect
    import flg_pkg::*;
#(
    parameter int DELAY_LENGTH    = DELAY_LENGTH_DEF,
    parameter int RATE_HZ         = RATE_HZ_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg               r_cfg;
    t_cmd               w_cmd;
    t_stat              w_stat;
    logic               w_cfg_wr;
    logic signed [15:0] w_sample_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step    <= '0;
            r_cfg.mod_depth     <= '0;
            r_cfg.feedback_gain <= '0;
            r_cfg.wet_mix       <= 16'd16384;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_PHASE_STEP:    r_cfg.phase_step    <= pwdata[30:0];
                REG_MOD_DEPTH:     r_cfg.mod_depth     <= pwdata[15:0];
                REG_FEEDBACK_GAIN: r_cfg.feedback_gain <= $signed(pwdata[15:0]);
                REG_WET_MIX:       r_cfg.wet_mix       <= pwdata[15:0];
                default:           r_cfg.wet_mix       <= r_cfg.wet_mix;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PHASE_STEP:    prdata = {1'b0, r_cfg.phase_step};
            REG_MOD_DEPTH:     prdata = {16'd0, r_cfg.mod_depth};
            REG_FEEDBACK_GAIN: prdata = {16'd0, r_cfg.feedback_gain};
            REG_WET_MIX:       prdata = {16'd0, r_cfg.wet_mix};
            default:           prdata = '0;
        endcase
    end

    flg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    flg_dp #(
        .DELAY_LENGTH    (DELAY_LENGTH),
        .RATE_HZ         (RATE_HZ),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_cfg    (r_cfg),
        .i_sample ($signed(s_axis_tdata)),
        .o_sample (w_sample_out),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = w_sample_out;

    // one item at a time: an accepted item closes the input until it is done
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // a new result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_MIX) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("output register overwritten while full");

    // the clearing pass runs before any item is taken
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("input ready before delay memory cleared");

endmodule
